/* src/rsc_pkg.sv */
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared widths, defaults and codes of the rank-sum count table.
// ----------------------------------------------------------------------------
package rsc_pkg;

  localparam int STAT_W         = 10;
  localparam int SIZE_W         = 5;
  localparam int WAYS_W         = 57;
  localparam int CFG_IDX_W      = 1;
  localparam int DEF_MAX_SIZE   = 30;
  localparam int DEF_HALF_DEPTH = 451;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_FIRST  = 1'd0,
    REG_SIZE_SECOND = 1'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_STEP_A,
    ST_STEP_B,
    ST_SUM,
    ST_DRAIN
  } state_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_SUB,
    OP_ADD,
    OP_SUM
  } op_e;

endpackage

/* src/rank_sum_count_table.sv */
// ----------------------------------------------------------------------------
// rank_sum_count_table
// Exact Mann-Whitney counts for sample sizes m and n: count at k, count up
// to k, and choose(m+n, n), served from a half-range table rebuilt after
// each size write.
// ----------------------------------------------------------------------------
//   channel   signals                                   flow
//   command   start, busy, statistic_i                  in, taken on start & !busy
//   result    done_o, ways_equal_o, ways_at_most_o,     out, one-cycle strobe
//             ways_total_o
//   config    cfg_we_i, cfg_index_i, cfg_data_i         in, taken on cfg_we_i
//
// A word passes the statistic register, the store read and the result
// register on its way to the result ports; with a valid table one word is
// taken every cycle (two store reads per word). The first word after reset
// or a size write rebuilds the coefficient memory and the store first, one
// coefficient update per cycle on the coefficient memory's single write port.
// busy is high during the rebuild. The receiver cannot stall.
// ----------------------------------------------------------------------------
module rank_sum_count_table
  import rsc_pkg::*;
#(
  parameter int MAX_SIZE   = DEF_MAX_SIZE,
  parameter int HALF_DEPTH = DEF_HALF_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [STAT_W-1:0]    statistic_i,
  output logic                 done_o,
  output logic [WAYS_W-1:0]    ways_equal_o,
  output logic [WAYS_W-1:0]    ways_at_most_o,
  output logic [WAYS_W-1:0]    ways_total_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [SIZE_W-1:0]    cfg_data_i
);

  localparam int POLY_LEN = MAX_SIZE * (MAX_SIZE + 1) + 1;
  localparam int IW       = $clog2(POLY_LEN);
  localparam int QW       = (IW > STAT_W) ? IW : STAT_W;
  localparam int SAW      = $clog2(HALF_DEPTH);

  // configuration
  logic [SIZE_W-1:0] size_first_q, size_second_q;
  logic [SIZE_W-1:0] m, n;
  logic [IW-1:0]     prod, half;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_first_q  <= SIZE_W'(1);
      size_second_q <= SIZE_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_SIZE_FIRST:  size_first_q  <= cfg_data_i;
        REG_SIZE_SECOND: size_second_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    m = size_first_q;
    if (size_first_q == '0) begin
      m = SIZE_W'(1);
    end else if (size_first_q > SIZE_W'(MAX_SIZE)) begin
      m = SIZE_W'(MAX_SIZE);
    end
    n = size_second_q;
    if (size_second_q == '0) begin
      n = SIZE_W'(1);
    end else if (size_second_q > SIZE_W'(MAX_SIZE)) begin
      n = SIZE_W'(MAX_SIZE);
    end
  end

  assign prod = IW'(m) * IW'(n);
  assign half = prod >> 1;

  // build control
  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [IW-1:0]     d_q, d_d;
  logic [IW-1:0]     top_q, top_d;
  logic [IW-1:0]     od_q, od_d;
  logic [SIZE_W-1:0] i_q, i_d;
  logic [WAYS_W-1:0] tot_q, tot_d;
  logic [WAYS_W-1:0] run_q, run_d;
  logic [WAYS_W-1:0] total_q, total_d;
  logic              ready_q, ready_d;
  logic              q1_v_q, q1_v_d;
  logic [STAT_W-1:0] k_q;

  // coefficient memory and forwarding
  logic              p_we;
  logic [IW-1:0]     p_waddr, p_ra, p_rb, p_ra_q, p_rb_q;
  logic [WAYS_W-1:0] p_wdata, p_rda, p_rdb, pa, pb;
  logic              fwd_v_q;
  logic [IW-1:0]     fwd_addr_q;
  logic [WAYS_W-1:0] fwd_data_q;

  // count store: {freq, prefix}
  logic                  s_we;
  logic [SAW-1:0]        s_waddr;
  logic [2*WAYS_W-1:0]   s_wdata, s_rda, s_rdb;
  logic [SAW-1:0]        s_ra, s_rb;

  logic [IW-1:0] s_a;
  logic [IW-1:0] clr_last;
  logic          accept;

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign s_a      = IW'(n) + IW'(i_q);
  assign clr_last = prod + IW'(m);

  assign pa = (fwd_v_q && (fwd_addr_q == p_ra_q)) ? fwd_data_q : p_rda;
  assign pb = (fwd_v_q && (fwd_addr_q == p_rb_q)) ? fwd_data_q : p_rdb;

  rsc_ram #(
    .WIDTH (WAYS_W),
    .DEPTH (POLY_LEN)
  ) u_poly_ram (
    .clk_i     (clk_i),
    .we_i      (p_we),
    .waddr_i   (p_waddr),
    .wdata_i   (p_wdata),
    .raddr_a_i (p_ra),
    .raddr_b_i (p_rb),
    .rdata_a_o (p_rda),
    .rdata_b_o (p_rdb)
  );

  rsc_ram #(
    .WIDTH (2 * WAYS_W),
    .DEPTH (HALF_DEPTH)
  ) u_store_ram (
    .clk_i     (clk_i),
    .we_i      (s_we),
    .waddr_i   (s_waddr),
    .wdata_i   (s_wdata),
    .raddr_a_i (s_ra),
    .raddr_b_i (s_rb),
    .rdata_a_o (s_rda),
    .rdata_b_o (s_rdb)
  );

  always_comb begin
    state_d = state_q;
    op_d    = OP_NONE;
    d_d     = d_q;
    top_d   = top_q;
    od_d    = d_q;
    i_d     = i_q;
    tot_d   = tot_q;
    run_d   = run_q;
    total_d = total_q;
    ready_d = ready_q;
    q1_v_d  = 1'b0;
    p_we    = 1'b0;
    p_waddr = od_q;
    p_wdata = '0;
    p_ra    = d_q;
    p_rb    = d_q;
    s_we    = 1'b0;
    s_waddr = SAW'(od_q);

    // execute the update whose operands arrive this cycle
    unique case (op_q)
      OP_SUB: begin
        p_we    = 1'b1;
        p_wdata = pa - pb;
      end
      OP_ADD: begin
        p_we    = 1'b1;
        p_wdata = pa + pb;
      end
      OP_SUM: begin
        tot_d = tot_q + pa;
        if (od_q <= half) begin
          run_d = run_q + pa;
          s_we  = (32'(od_q) < HALF_DEPTH);
        end
      end
      default: ;
    endcase
    s_wdata = {pa, run_d};

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (ready_q) begin
            q1_v_d = 1'b1;
          end else begin
            state_d = ST_CLEAR;
            d_d     = '0;
          end
        end
      end
      ST_CLEAR: begin
        p_we    = 1'b1;
        p_waddr = d_q;
        p_wdata = (d_q == '0) ? WAYS_W'(1) : '0;
        if (d_q == clr_last) begin
          i_d     = SIZE_W'(1);
          top_d   = IW'(n) + IW'(1);
          d_d     = IW'(n) + IW'(1);
          state_d = ST_STEP_A;
        end else begin
          d_d = d_q + IW'(1);
        end
      end
      ST_STEP_A: begin
        // multiply by (1 - q^s), high index first
        p_rb = d_q - s_a;
        op_d = OP_SUB;
        if (d_q == s_a) begin
          d_d     = IW'(i_q);
          state_d = ST_STEP_B;
        end else begin
          d_d = d_q - IW'(1);
        end
      end
      ST_STEP_B: begin
        // divide by (1 - q^i), low index first
        p_rb = d_q - IW'(i_q);
        op_d = OP_ADD;
        if (d_q == top_q) begin
          if (i_q == m) begin
            d_d     = '0;
            tot_d   = '0;
            run_d   = '0;
            state_d = ST_SUM;
          end else begin
            i_d     = i_q + SIZE_W'(1);
            top_d   = top_q + IW'(n) + IW'(1);
            d_d     = top_q + IW'(n) + IW'(1);
            state_d = ST_STEP_A;
          end
        end else begin
          d_d = d_q + IW'(1);
        end
      end
      ST_SUM: begin
        op_d = OP_SUM;
        if (d_q == prod) begin
          state_d = ST_DRAIN;
        end else begin
          d_d = d_q + IW'(1);
        end
      end
      ST_DRAIN: begin
        total_d = tot_d;
        ready_d = 1'b1;
        q1_v_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase

    if (cfg_we_i) begin
      ready_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_NONE;
      ready_q <= 1'b0;
      q1_v_q  <= 1'b0;
      fwd_v_q <= 1'b0;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      ready_q <= ready_d;
      q1_v_q  <= q1_v_d;
      fwd_v_q <= p_we;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q        <= d_d;
    top_q      <= top_d;
    od_q       <= od_d;
    i_q        <= i_d;
    tot_q      <= tot_d;
    run_q      <= run_d;
    p_ra_q     <= p_ra;
    p_rb_q     <= p_rb;
    fwd_addr_q <= p_waddr;
    fwd_data_q <= p_wdata;
    if (accept) begin
      k_q <= statistic_i;
    end
  end

  // query, stage 1: store addresses
  logic [QW-1:0] kx, prodq, mir, addr_a, addr_b;
  logic          over, low;

  assign kx     = QW'(k_q);
  assign prodq  = QW'(prod);
  assign over   = (kx > prodq);
  assign low    = (kx <= QW'(half));
  assign mir    = prodq - kx;
  assign addr_a = low ? kx : mir;
  assign addr_b = mir - QW'(1);
  assign s_ra   = SAW'(addr_a);
  assign s_rb   = SAW'(addr_b);

  logic q2_v_q, over_q, low_q, mirz_q, ain_q, bin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q2_v_q <= 1'b0;
    end else begin
      q2_v_q <= q1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    over_q <= over;
    low_q  <= low;
    mirz_q <= (mir == '0);
    ain_q  <= (32'(addr_a) < HALF_DEPTH);
    bin_q  <= (32'(addr_b) < HALF_DEPTH);
  end

  // query, stage 2: result word
  logic [WAYS_W-1:0] fa, pfa, pfb, eq, atmost;
  logic              done_q;
  logic [WAYS_W-1:0] eq_q, atmost_q;

  assign fa  = ain_q ? s_rda[2*WAYS_W-1:WAYS_W] : '0;
  assign pfa = ain_q ? s_rda[WAYS_W-1:0] : '0;
  assign pfb = bin_q ? s_rdb[WAYS_W-1:0] : '0;

  always_comb begin
    eq     = fa;
    atmost = total_q - pfb;
    priority if (over_q) begin
      eq     = '0;
      atmost = total_q;
    end else if (low_q) begin
      atmost = pfa;
    end else if (mirz_q) begin
      atmost = total_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= q2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    eq_q     <= eq;
    atmost_q <= atmost;
  end

  assign done_o         = done_q;
  assign ways_equal_o   = eq_q;
  assign ways_at_most_o = atmost_q;
  assign ways_total_o   = total_q;

  // checks
  a_query_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q1_v_q |-> (state_q == ST_IDLE))
    else $error("query issued during table build");

  a_ready_from_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ready_q) |-> $past(state_q == ST_DRAIN))
    else $error("table marked ready outside build end");

  a_drain_injects: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |=> (q1_v_q && (state_q == ST_IDLE)))
    else $error("pending word not issued after build");

  a_sum_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_q == OP_SUM) |-> ((state_q == ST_SUM) || (state_q == ST_DRAIN)))
    else $error("store write outside summing pass");

  a_clear_no_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> (op_q == OP_NONE))
    else $error("coefficient update overlaps clearing pass");

endmodule

/* src/rsc_ram.sv */
// ----------------------------------------------------------------------------
// rsc_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module rsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule
